@@ design/fr_pkg.sv @@
// Shared command and status types for the fraction reducer.
package fr_pkg;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // capture magnitudes and signs of the operands
    logic halve;     // strip a common factor of two from both operands
    logic reduce;    // one binary gcd step
    logic div_init;  // set up both dividers with the gcd as divisor
    logic div_step;  // one restoring division step in both dividers
    logic out_load;  // transfer the final result into the output register
  } fr_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic zero_operand;  // numerator or denominator is zero
    logic odd_found;     // at least one operand is odd
    logic gcd_found;     // both operands equal: odd part of the gcd found
  } fr_sts_t;

endpackage

@@ design/fraction_reducer.sv @@
// Fraction reducer: binary gcd then two parallel restoring divisions, one fraction at a time.
// The binary gcd steps follow the removal of the shared power of two; when either part is zero,
// the gcd search and the divisions are skipped.
// Next input is taken the cycle after the result is loaded into the output register.
// Asynchronous active-low reset returns the sequencer to idle and clears out_valid_o.
module fraction_reducer #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORD_BITS-1:0] numerator_in_i,
  input  logic signed [WORD_BITS-1:0] denominator_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] numerator_out_o,
  output logic        [WORD_BITS-2:0] denominator_out_o,
  output logic                        zero_divisor_o
);
  import fr_pkg::*;

  fr_cmd_t cmd;
  fr_sts_t sts;

  fr_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fr_dpath #(
    .WORD_BITS(WORD_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .numerator_in_i   (numerator_in_i),
    .denominator_in_i (denominator_in_i),
    .numerator_out_o  (numerator_out_o),
    .denominator_out_o(denominator_out_o),
    .zero_divisor_o   (zero_divisor_o)
  );

endmodule

@@ design/fr_dpath.sv @@
// Datapath: operand magnitudes, binary gcd, two restoring dividers, result formatting.
module fr_dpath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fr_pkg::fr_cmd_t             cmd_i,
  output fr_pkg::fr_sts_t             sts_o,
  input  logic signed [WORD_BITS-1:0] numerator_in_i,
  input  logic signed [WORD_BITS-1:0] denominator_in_i,
  output logic signed [WORD_BITS-1:0] numerator_out_o,
  output logic        [WORD_BITS-2:0] denominator_out_o,
  output logic                        zero_divisor_o
);
  import fr_pkg::*;

  localparam int unsigned KW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] PMAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  logic [WORD_BITS-1:0] nm_q, nm_d, dm_q, dm_d;   // magnitudes
  logic                 nneg_q, nneg_d, dneg_q, dneg_d;
  logic [WORD_BITS-1:0] a_q, a_d, b_q, b_d;       // gcd working operands
  logic [KW-1:0]        k_q, k_d;                 // shared power of two
  logic [WORD_BITS-1:0] g_q, g_d;                 // gcd
  logic [WORD_BITS-1:0] nq_q, nq_d, dq_q, dq_d;   // quotients
  logic [WORD_BITS-1:0] nr_q, nr_d, dr_q, dr_d;   // remainders

  logic [WORD_BITS:0]   nr_sh, dr_sh, n_diff, d_diff;
  logic [WORD_BITS-1:0] onum;
  logic [WORD_BITS-2:0] oden;
  logic                 a_zero, b_zero;

  logic signed [WORD_BITS-1:0] num_out_q, num_out_d;
  logic        [WORD_BITS-2:0] den_out_q, den_out_d;
  logic                        zd_out_q, zd_out_d;

  assign a_zero = (a_q == '0);
  assign b_zero = (b_q == '0);

  assign sts_o.zero_operand = a_zero | b_zero;
  assign sts_o.odd_found    = a_q[0] | b_q[0];
  assign sts_o.gcd_found    = (a_q == b_q);

  // restoring division: shift one dividend bit into each remainder
  assign nr_sh  = {nr_q, nq_q[WORD_BITS-1]};
  assign dr_sh  = {dr_q, dq_q[WORD_BITS-1]};
  assign n_diff = nr_sh - {1'b0, g_q};
  assign d_diff = dr_sh - {1'b0, g_q};

  always_comb begin
    nm_d   = nm_q;
    dm_d   = dm_q;
    nneg_d = nneg_q;
    dneg_d = dneg_q;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    nq_d   = nq_q;
    dq_d   = dq_q;
    nr_d   = nr_q;
    dr_d   = dr_q;

    if (cmd_i.load) begin
      // negating the most negative value yields 2^(W-1), still exact unsigned
      nneg_d = numerator_in_i[WORD_BITS-1];
      dneg_d = denominator_in_i[WORD_BITS-1];
      nm_d   = nneg_d ? (~numerator_in_i + 1'b1) : numerator_in_i;
      dm_d   = dneg_d ? (~denominator_in_i + 1'b1) : denominator_in_i;
      a_d    = nm_d;
      b_d    = dm_d;
      k_d    = '0;
    end else if (cmd_i.halve) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + 1'b1;
    end else if (cmd_i.reduce) begin
      if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end

    if (cmd_i.div_init) begin
      g_d  = a_q << k_q;
      nq_d = nm_q;
      dq_d = dm_q;
      nr_d = '0;
      dr_d = '0;
    end else if (cmd_i.div_step) begin
      if (!n_diff[WORD_BITS]) begin
        nr_d = n_diff[WORD_BITS-1:0];
        nq_d = {nq_q[WORD_BITS-2:0], 1'b1};
      end else begin
        nr_d = nr_sh[WORD_BITS-1:0];
        nq_d = {nq_q[WORD_BITS-2:0], 1'b0};
      end
      if (!d_diff[WORD_BITS]) begin
        dr_d = d_diff[WORD_BITS-1:0];
        dq_d = {dq_q[WORD_BITS-2:0], 1'b1};
      end else begin
        dr_d = dr_sh[WORD_BITS-1:0];
        dq_d = {dq_q[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  // sign goes to the numerator; positive results that overflow saturate
  always_comb begin
    if (nneg_q ^ dneg_q) begin
      onum = ~nq_q + 1'b1;
    end else if (nq_q[WORD_BITS-1]) begin
      onum = PMAX;
    end else begin
      onum = nq_q;
    end
    oden = dq_q[WORD_BITS-1] ? PMAX[WORD_BITS-2:0] : dq_q[WORD_BITS-2:0];
  end

  always_comb begin
    num_out_d = num_out_q;
    den_out_d = den_out_q;
    zd_out_d  = zd_out_q;
    if (cmd_i.out_load) begin
      if (a_zero | b_zero) begin
        num_out_d = '0;
        den_out_d = (WORD_BITS-1)'(1);
        zd_out_d  = b_zero;
      end else begin
        num_out_d = onum;
        den_out_d = oden;
        zd_out_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_q      <= '0;
      dm_q      <= '0;
      nneg_q    <= 1'b0;
      dneg_q    <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      g_q       <= '0;
      nq_q      <= '0;
      dq_q      <= '0;
      nr_q      <= '0;
      dr_q      <= '0;
      num_out_q <= '0;
      den_out_q <= '0;
      zd_out_q  <= 1'b0;
    end else begin
      nm_q      <= nm_d;
      dm_q      <= dm_d;
      nneg_q    <= nneg_d;
      dneg_q    <= dneg_d;
      a_q       <= a_d;
      b_q       <= b_d;
      k_q       <= k_d;
      g_q       <= g_d;
      nq_q      <= nq_d;
      dq_q      <= dq_d;
      nr_q      <= nr_d;
      dr_q      <= dr_d;
      num_out_q <= num_out_d;
      den_out_q <= den_out_d;
      zd_out_q  <= zd_out_d;
    end
  end

  assign numerator_out_o   = num_out_q;
  assign denominator_out_o = den_out_q;
  assign zero_divisor_o    = zd_out_q;

endmodule

@@ design/fr_ctrl.sv @@
// Sequencer: steps one fraction through gcd search and division, owns the handshakes.
module fr_ctrl #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fr_pkg::fr_cmd_t cmd_o,
  input  fr_pkg::fr_sts_t sts_i
);
  import fr_pkg::*;

  localparam int unsigned CW = $clog2(WORD_BITS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SHIFT  = 5'b00010,
    ST_REDUCE = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } fr_state_e;

  fr_state_e     state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts_i.zero_operand) begin
          state_d = ST_FINISH;
        end else if (sts_i.odd_found) begin
          state_d = ST_REDUCE;
        end else begin
          cmd_o.halve = 1'b1;
        end
      end
      ST_REDUCE: begin
        if (sts_i.gcd_found) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIVIDE;
        end else begin
          cmd_o.reduce = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CW'(WORD_BITS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free for the transfer
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
